>>> rtl/core/nca_pkg.sv
// ============================================================================
// nca_pkg: shared types and constants for the nearest-center assign block
// Beat structs, field widths, action and register codes, control state.
// ============================================================================
package nca_pkg;

    // Coordinate format is fixed: signed Q7.8, eight fields per beat
    localparam int COORD_BITS  = 16;
    localparam int NUM_COORDS  = 8;
    localparam int SLOT_W      = 4;
    localparam int INDEX_W     = 4;
    localparam int DIST_W      = 35;
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int SQ_W        = 2 * DIFF_W - 1;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;
    localparam int NCENT_W     = 5;
    localparam int NDIMS_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CENTERS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS    = 1'b1;

    localparam logic ACT_LOAD     = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] center_slot;
        coord_t            coord_0;
        coord_t            coord_1;
        coord_t            coord_2;
        coord_t            coord_3;
        coord_t            coord_4;
        coord_t            coord_5;
        coord_t            coord_6;
        coord_t            coord_7;
    } item_beat_t;

    typedef struct packed {
        logic [INDEX_W-1:0] cluster_index;
        logic [DIST_W-1:0]  squared_distance;
    } result_beat_t;

    // Tag that travels with one center through the pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } stage_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

endpackage

>>> rtl/core/nearest_center_assign.sv
// ============================================================================
// nearest_center_assign: k-means nearest-center assignment
// Center memory, dimension lanes, merge tree and a scan sequencer.
// ============================================================================
// Usage:
//   item channel (item_valid/item_ready/item): one beat is either a load
//   (action = load) that writes all coordinates into the center slot, or a
//   classify beat carrying one point. Loads produce no result beat.
//   result channel (result_valid/result_ready/result): one beat per classify,
//   giving the nearest active center and its exact squared distance; on a
//   tie the lowest index wins.
//   cfg port (cfg_we/cfg_index/cfg_data): num_centers and num_dims, to be written
//   only while the block is idle; the block itself does not enforce this.
// Timing:
//   A classify scans one center per cycle through the memory read, lane
//   squaring, merge sum and compare stages. item_ready returns in the same
//   cycle that result_valid rises, so no new item is taken while a classify
//   is in flight. The scan through the center memory's single read port
//   sets the rate.
// Reset: all centers read as zero, num_centers = 1, num_dims = 1.
// Stall: a finished result waits in the output register while the next item
//   is taken; a second result then waits in the merge stage until the first
//   beat is taken.
// ============================================================================
module nearest_center_assign #(
    parameter int MAX_CENTERS = 16,
    parameter int MAX_DIMS    = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  nca_pkg::item_beat_t             item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output nca_pkg::result_beat_t           result,
    input  logic                            cfg_we,
    input  logic [nca_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nca_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import nca_pkg::*;

    localparam int IDX_W  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int WORD_W = MAX_DIMS * COORD_BITS;

    // configuration
    logic [NCENT_W-1:0] num_centers_reg;
    logic [NDIMS_W-1:0] num_dims_reg;

    // sequencer
    state_t            state_reg;
    state_t            state_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  last_idx;
    logic              issue;
    logic              res_ack;
    logic              accept;
    logic              load_wr;

    // point and pipeline tags
    coord_t            coords_in [NUM_COORDS];
    coord_t            pt_reg [MAX_DIMS];
    logic [WORD_W-1:0] load_word;
    stage_ctl_t        ctl0;
    stage_ctl_t        ctl1_reg;
    stage_ctl_t        ctl2_reg;
    logic [IDX_W-1:0]  idx1_reg;
    logic [IDX_W-1:0]  idx2_reg;

    logic [WORD_W-1:0] rd_data;
    logic [SQ_W-1:0]   sq [MAX_DIMS];

    logic              res_valid;
    logic [IDX_W-1:0]  best_idx;
    logic [DIST_W-1:0] best_dist;

    logic              out_valid_reg;
    result_beat_t      out_reg;

    assign coords_in[0] = item.coord_0;
    assign coords_in[1] = item.coord_1;
    assign coords_in[2] = item.coord_2;
    assign coords_in[3] = item.coord_3;
    assign coords_in[4] = item.coord_4;
    assign coords_in[5] = item.coord_5;
    assign coords_in[6] = item.coord_6;
    assign coords_in[7] = item.coord_7;

    genvar g;
    generate
        for (g = 0; g < MAX_DIMS; g++)
        begin : g_word
            assign load_word[g*COORD_BITS +: COORD_BITS] = coords_in[g];
        end
    endgenerate

    assign accept  = item_valid && item_ready;
    assign load_wr = accept && (item.action == ACT_LOAD)
                     && (int'(item.center_slot) < MAX_CENTERS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_centers_reg <= NCENT_W'(1);
            num_dims_reg    <= NDIMS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_CENTERS: num_centers_reg <= cfg_data[NCENT_W-1:0];
                CFG_NUM_DIMS:    num_dims_reg    <= cfg_data[NDIMS_W-1:0];
                default:         ;
            endcase
        end
    end

    // last center scanned: zero centers act as one, clamp to the store depth
    always_comb
    begin
        if (num_centers_reg == '0)
        begin
            last_idx = '0;
        end
        else if (int'(num_centers_reg) > MAX_CENTERS)
        begin
            last_idx = IDX_W'(MAX_CENTERS - 1);
        end
        else
        begin
            last_idx = IDX_W'(num_centers_reg - NCENT_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Scan sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        item_ready = 1'b0;
        issue      = 1'b0;
        res_ack    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid && (item.action == ACT_CLASSIFY))
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                end
            end
            ST_SCAN:
            begin
                issue = 1'b1;
                if (idx_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (res_valid && (!out_valid_reg || result_ready))
                begin
                    res_ack    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ctl0.valid = issue;
    assign ctl0.first = (idx_reg == '0);
    assign ctl0.last  = (idx_reg == last_idx);

    // point held for the whole scan
    always_ff @(posedge clk)
    begin
        if (accept && (item.action == ACT_CLASSIFY))
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                pt_reg[d] <= coords_in[d];
            end
        end
        idx1_reg <= idx_reg;
        idx2_reg <= idx1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl0;
            ctl2_reg <= ctl1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Datapath: memory read, lanes, merge
    // ------------------------------------------------------------------
    nca_store #(
        .DEPTH  (MAX_CENTERS),
        .ADDR_W (IDX_W),
        .WORD_W (WORD_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_wr),
        .wr_addr (IDX_W'(item.center_slot)),
        .wr_data (load_word),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    generate
        for (g = 0; g < MAX_DIMS; g++)
        begin : g_lane
            nca_lane u_lane (
                .clk    (clk),
                .pt     (pt_reg[g]),
                .ctr    (rd_data[g*COORD_BITS +: COORD_BITS]),
                .active (NDIMS_W'(g) < num_dims_reg),
                .sq     (sq[g])
            );
        end
    endgenerate

    nca_merge #(
        .LANES (MAX_DIMS),
        .IDX_W (IDX_W)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .sq        (sq),
        .ctl_in    (ctl2_reg),
        .idx_in    (idx2_reg),
        .res_ack   (res_ack),
        .res_valid (res_valid),
        .best_idx  (best_idx),
        .best_dist (best_dist)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ack)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            out_reg.cluster_index    <= INDEX_W'(best_idx);
            out_reg.squared_distance <= best_dist;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        res_ack |-> state_reg == ST_DRAIN)
        else $error("result handed over outside the drain phase");
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !ctl1_reg.valid && !ctl2_reg.valid && !res_valid)
        else $error("idle while a scan is still in flight");
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> idx_reg <= last_idx)
        else $error("scan index past the last active center");
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_ready |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result beat overwritten");
`endif

endmodule

>>> rtl/core/nca_store.sv
// ============================================================================
// nca_store: center memory
// One write port, one registered read port; entries never loaded read as zero.
// ============================================================================
module nca_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int WORD_W = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);
    import nca_pkg::*;

    logic [WORD_W-1:0] mem_reg [DEPTH];
    logic [WORD_W-1:0] rd_word_reg;
    logic [DEPTH-1:0]  loaded_reg;
    logic              rd_loaded_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_word_reg <= mem_reg[rd_addr];
    end

    // per-entry loaded flags stand in for clearing the array at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            rd_loaded_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                loaded_reg[wr_addr] <= 1'b1;
            end
            rd_loaded_reg <= loaded_reg[rd_addr];
        end
    end

    assign rd_data = rd_loaded_reg ? rd_word_reg : '0;

endmodule

>>> rtl/core/nca_lane.sv
// ============================================================================
// nca_lane: one dimension lane
// Squared difference of one point coordinate and one center coordinate.
// ============================================================================
module nca_lane (
    input  logic                 clk,
    input  nca_pkg::coord_t      pt,
    input  nca_pkg::coord_t      ctr,
    input  logic                 active,
    output logic [nca_pkg::SQ_W-1:0] sq
);
    import nca_pkg::*;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [2*DIFF_W-1:0] prod;
    logic [SQ_W-1:0]            sq_reg;

    assign diff = DIFF_W'(pt) - DIFF_W'(ctr);
    assign prod = diff * diff;

    // inactive dimensions contribute nothing
    always_ff @(posedge clk)
    begin
        sq_reg <= active ? SQ_W'(prod) : '0;
    end

    assign sq = sq_reg;

endmodule

>>> rtl/core/nca_merge.sv
// ============================================================================
// nca_merge: lane merge and running minimum
// Sums the lane squares, then keeps the nearest center so far (strict compare).
// ============================================================================
module nca_merge #(
    parameter int LANES = 8,
    parameter int IDX_W = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [nca_pkg::SQ_W-1:0]     sq [LANES],
    input  nca_pkg::stage_ctl_t          ctl_in,
    input  logic [IDX_W-1:0]             idx_in,
    input  logic                         res_ack,
    output logic                         res_valid,
    output logic [IDX_W-1:0]             best_idx,
    output logic [nca_pkg::DIST_W-1:0]   best_dist
);
    import nca_pkg::*;

    logic [DIST_W-1:0] sum_next;
    logic [DIST_W-1:0] sum_reg;
    stage_ctl_t        ctl_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic              res_valid_reg;
    logic              take;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            sum_next = sum_next + DIST_W'(sq[i]);
        end
    end

    assign take = ctl_reg.first || (sum_reg < best_dist_reg);

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        idx_reg <= idx_in;
        if (ctl_reg.valid && take)
        begin
            best_dist_reg <= sum_reg;
            best_idx_reg  <= idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_reg <= ctl_in;
            if (ctl_reg.valid && ctl_reg.last)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ack)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign best_idx  = best_idx_reg;
    assign best_dist = best_dist_reg;

`ifndef SYNTHESIS
    a_first_never_mid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid && ctl_reg.first |-> !res_valid_reg)
        else $error("new point entered merge while a result was pending");
    a_ack_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_ack |-> res_valid_reg)
        else $error("result acknowledged with none pending");
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ack |=> res_valid_reg && $stable(best_dist_reg))
        else $error("pending result changed before acknowledge");
`endif

endmodule
